// File: sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/aes128_pkg.sv
// ----------------------------------------------------------------------------
// aes128_pkg
// Shared types, S-box table and GF(2^8) helpers for the AES-128 engine.
// ----------------------------------------------------------------------------
package aes128_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } seq_state_e;

  typedef struct packed {
    logic last;     // final round: skip MixColumns
    logic key_on;   // round keys valid; zero keys otherwise
  } round_ctrl_t;

  localparam logic [7:0] RCON_FIRST = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1B;
  localparam logic [3:0] LAST_ROUND = 4'd10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // byte i of a 128-bit block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
    get_byte = w[127 - 8 * i -: 8];
  endfunction

endpackage

// File: sv/aes128_key_step.sv
// ----------------------------------------------------------------------------
// aes128_key_step
// One step of the AES-128 key schedule: previous round key to next.
// ----------------------------------------------------------------------------
module aes128_key_step (
  input  logic [127:0] key_i,
  input  logic [7:0]   rcon_i,
  output logic [127:0] key_o
);
  import aes128_pkg::*;

  logic [31:0] w [4];
  logic [31:0] n [4];
  logic [31:0] t;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = key_i[127 - 32 * i -: 32];
    end
    // rotate, substitute, add round constant
    t = {SBOX[w[3][23:16]] ^ rcon_i, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
    n[0] = w[0] ^ t;
    n[1] = w[1] ^ n[0];
    n[2] = w[2] ^ n[1];
    n[3] = w[3] ^ n[2];
    key_o = {n[0], n[1], n[2], n[3]};
  end

endmodule

// File: sv/aes128_round.sv
// ----------------------------------------------------------------------------
// aes128_round
// Shared round unit: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// ----------------------------------------------------------------------------
module aes128_round (
  input  logic [127:0]             state_i,
  input  logic [127:0]             key_i,
  input  aes128_pkg::round_ctrl_t  ctrl_i,
  output logic [127:0]             state_o
);
  import aes128_pkg::*;

  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3, all;
  logic [127:0] packed_w;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4 * c] = SBOX[get_byte(state_i, r + 4 * ((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = t[4 * c];
      a1  = t[4 * c + 1];
      a2  = t[4 * c + 2];
      a3  = t[4 * c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (ctrl_i.last) begin
        m[4 * c]     = a0;
        m[4 * c + 1] = a1;
        m[4 * c + 2] = a2;
        m[4 * c + 3] = a3;
      end else begin
        m[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        m[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        m[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        m[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      packed_w[127 - 8 * i -: 8] = m[i];
    end
    state_o = packed_w ^ (ctrl_i.key_on ? key_i : 128'd0);
  end

endmodule

// File: sv/aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt
// Iterative AES-128 ECB encryption engine with an APB key port.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key over APB: key_high at address 0x0, key_low at 0x8
//   (64-bit data). Reads return the key registers. pready is always high.
//   Input channel: block_high_i/block_low_i with in_valid_i; the block
//   drives in_stall_o. Output channel: cipher_high_o/cipher_low_o with
//   out_valid_o; the receiver drives out_stall_i.
//   An item is accepted on the edge where valid is high and stall is low.
// Operation:
//   The accept edge applies the initial key XOR; the ten rounds then run
//   through one shared round unit while the key schedule advances one
//   step per cycle alongside. The last round's result goes to the output
//   register (see Stall), and a new item is taken only once the engine is
//   idle again, so the block works on one item at a time: the single round unit sets that.
//   in_stall_o is high while the rounds run.
// Stall:
//   A finished result sits in the output register until taken; if the
//   previous result is still waiting, hold the new one in the state
//   register and keep in_stall_o high until the output slot frees.
// Reset:
//   Keys clear to zero and every round key reads as zero until the first
//   key write; no item is in flight.
// ----------------------------------------------------------------------------
module aes128_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o
);
  import aes128_pkg::*;

  logic [63:0]  key_high_q, key_low_q;
  logic         key_set_q;
  seq_state_e   st_q, st_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [127:0] state_q, state_d;
  logic [127:0] rk_q, rk_d, rk_next, round_out;
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_q, out_d;
  logic         in_acc, out_free, cfg_wr;
  round_ctrl_t  ctrl;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = paddr[3] ? key_low_q : key_high_q;

  // key registers; any write turns the schedule on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      key_set_q  <= 1'b0;
    end else if (cfg_wr) begin
      key_set_q <= 1'b1;
      if (paddr[3]) begin
        key_low_q <= pwdata;
      end else begin
        key_high_q <= pwdata;
      end
    end
  end

  assign ctrl = '{last: (rnd_q == LAST_ROUND), key_on: key_set_q};

  aes128_key_step u_key (
    .key_i  (rk_q),
    .rcon_i (rcon_q),
    .key_o  (rk_next)
  );

  aes128_round u_round (
    .state_i (state_q),
    .key_i   (rk_next),
    .ctrl_i  (ctrl),
    .state_o (round_out)
  );

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    st_d        = st_q;
    rnd_d       = rnd_q;
    rcon_d      = rcon_q;
    state_d     = state_q;
    rk_d        = rk_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          // initial AddRoundKey: round key 0 is the key itself
          state_d = {block_high_i, block_low_i} ^ {key_high_q, key_low_q};
          rk_d    = {key_high_q, key_low_q};
          rcon_d  = RCON_FIRST;
          rnd_d   = 4'd1;
          st_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = round_out;
        rk_d    = rk_next;
        rcon_d  = xtime(rcon_q);
        rnd_d   = rnd_q + 4'd1;
        if (ctrl.last) begin
          if (out_free) begin
            out_d       = round_out;
            out_valid_d = 1'b1;
            st_d        = ST_IDLE;
          end else begin
            st_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_d       = state_q;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rk_q    <= rk_d;
    rcon_q  <= rcon_d;
    out_q   <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign cipher_high_o = out_q[127:64];
  assign cipher_low_o  = out_q[63:0];

endmodule

// File: sv/aes128_checker.sv
// ----------------------------------------------------------------------------
// aes128_checker
// Port-level checks for the AES-128 engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes128_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] cipher_high_o,
  input logic [63:0] cipher_low_o
);

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // and its payload holds
  `ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i,
               $stable(cipher_high_o) && $stable(cipher_low_o))
  // the engine goes busy right after taking an item
  `ASSERT_NEXT(a_busy_after_acc, in_valid_i && !in_stall_o, in_stall_o)
  // and it is still busy in the tenth round
  `ASSERT_NEXT(a_busy_rounds, in_valid_i && !in_stall_o, ##9 in_stall_o)

endmodule

bind aes128_block_encrypt aes128_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .cipher_high_o (cipher_high_o),
  .cipher_low_o  (cipher_low_o)
);

// File: tb/tb_aes128_block_encrypt.sv
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt
// Self-checking bench for the AES-128 block engine: APB key writes between
// phases, directed and random blocks, predicted ciphertext compared per field.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt;

  localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
  localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;
  localparam int         WATCHDOG_MAX  = 5000;
  localparam int         HOLD_CYCLES   = 80;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef logic [7:0] state_t [16];

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] block_high_i;
  logic [63:0] block_low_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;

  aes128_block_encrypt dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .block_high_i, .block_low_i,
    .out_valid_o, .out_stall_i, .cipher_high_o, .cipher_low_o
  );

  // Predictor state: key registers and the expanded round keys.
  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [127:0] round_keys [11];

  block_t pending_blocks[$];
  block_t expected_cipher[$];
  int     errors;
  int     idle_pct;
  int     stall_pct;
  int     hold_left = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  logic   in_taken = 1'b0;
  int     quiet_cycles;
  int     accepted_in;
  int     accepted_out;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic state_t to_bytes(input logic [127:0] w);
    state_t s;
    for (int i = 0; i < 16; i++) s[i] = w[127 - 8 * i -: 8];
    return s;
  endfunction

  function automatic logic [127:0] from_bytes(input state_t s);
    logic [127:0] w;
    for (int i = 0; i < 16; i++) w[127 - 8 * i -: 8] = s[i];
    return w;
  endfunction

  // Recompute all eleven round keys from the current key pair.
  task automatic expand_round_keys();
    logic [7:0] rc [10];
    state_t p;
    state_t c;
    rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
    round_keys[0] = {key_hi_q, key_lo_q};
    for (int r = 1; r <= 10; r++) begin
      p = to_bytes(round_keys[r - 1]);
      c[0] = p[0] ^ aes128_pkg::SBOX[p[13]] ^ rc[r - 1];
      c[1] = p[1] ^ aes128_pkg::SBOX[p[14]];
      c[2] = p[2] ^ aes128_pkg::SBOX[p[15]];
      c[3] = p[3] ^ aes128_pkg::SBOX[p[12]];
      for (int i = 4; i < 16; i++) c[i] = p[i] ^ c[i - 4];
      round_keys[r] = from_bytes(c);
    end
  endtask

  function automatic block_t encrypt_block(input block_t pt);
    state_t s;
    state_t t;
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] w;
    w = {pt.hi, pt.lo} ^ round_keys[0];
    s = to_bytes(w);
    for (int r = 1; r <= 10; r++) begin
      for (int col = 0; col < 4; col++)
        for (int row = 0; row < 4; row++)
          t[row + 4 * col] = aes128_pkg::SBOX[s[row + 4 * ((col + row) & 3)]];
      s = t;
      if (r != 10) begin
        for (int col = 0; col < 4; col++) begin
          a0 = s[4*col]; a1 = s[4*col+1]; a2 = s[4*col+2]; a3 = s[4*col+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          s[4*col]   = a0 ^ all ^ gf_double(a0 ^ a1);
          s[4*col+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          s[4*col+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          s[4*col+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      s = to_bytes(from_bytes(s) ^ round_keys[r]);
    end
    w = from_bytes(s);
    return '{hi: w[127:64], lo: w[63:0]};
  endfunction

  // Receiver hold: count down a long stall stretch once per request.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= hold_req;
    end
  end

  // Driver: present the head of the pending queue; advance on accept.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) void'(pending_blocks.pop_front());
      if ((in_valid_i && !in_taken) ||
          (pending_blocks.size() > 0 && $urandom_range(99) >= idle_pct)) begin
        in_valid_i   <= 1'b1;
        block_high_i <= pending_blocks[0].hi;
        block_low_i  <= pending_blocks[0].lo;
      end else begin
        in_valid_i <= 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Monitor: predict on input accept, check on output accept.
  always @(posedge clk_i) begin
    block_t got;
    block_t exp_c;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (in_valid_i && !in_stall_o) begin
        expected_cipher.push_back(encrypt_block('{hi: block_high_i, lo: block_low_i}));
        accepted_in++;
      end
      if (out_valid_o && !out_stall_i) begin
        accepted_out++;
        got = '{hi: cipher_high_o, lo: cipher_low_o};
        if (expected_cipher.size() == 0) begin
          errors++;
          $display("%0t: unexpected cipher %h %h", $time, got.hi, got.lo);
        end else begin
          exp_c = expected_cipher.pop_front();
          if (got.hi !== exp_c.hi) begin
            errors++;
            $display("%0t: cipher_high expected %h got %h", $time, exp_c.hi, got.hi);
          end
          if (got.lo !== exp_c.lo) begin
            errors++;
            $display("%0t: cipher_low expected %h got %h", $time, exp_c.lo, got.lo);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t: watchdog, nothing accepted for %0d cycles", $time, quiet_cycles);
        $display("RESULT: ERROR");
        $finish;
      end
    end else begin
      in_taken = 1'b0;
    end
  end

  // APB write: setup cycle, access cycle; pready is tied high.
  task automatic write_key(input logic [3:0] addr, input logic [63:0] value);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_KEY_HIGH) key_hi_q = value;
    else if (addr == ADDR_KEY_LOW) key_lo_q = value;
    expand_round_keys();
  endtask

  // Wait for the queues to drain, then let the engine settle.
  task automatic drain();
    while (pending_blocks.size() > 0 || expected_cipher.size() > 0) @(negedge clk_i);
    repeat (15) @(negedge clk_i);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++)
      pending_blocks.push_back('{hi: {$urandom, $urandom}, lo: {$urandom, $urandom}});
  endtask

  initial begin
    block_t directed [$];
    errors = 0; idle_pct = 0; stall_pct = 0; quiet_cycles = 0;
    accepted_in = 0; accepted_out = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; out_stall_i = 0; block_high_i = '0; block_low_i = '0;
    key_hi_q = '0; key_lo_q = '0;
    // Round keys read as zero until the first key write, not the zero-key schedule.
    for (int r = 0; r < 11; r++) round_keys[r] = '0;
    rst_ni = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1;

    // Encrypt before any key write: all round keys zero.
    directed = '{'{hi: '0, lo: '0}, '{hi: '1, lo: '1},
                 '{hi: 64'h00112233_44556677, lo: 64'h8899aabb_ccddeeff}};
    foreach (directed[i]) pending_blocks.push_back(directed[i]);
    drain();

    // Published vector key, then extremes of the key and block fields.
    write_key(ADDR_KEY_HIGH, 64'h00010203_04050607);
    write_key(ADDR_KEY_LOW, 64'h08090a0b_0c0d0e0f);
    foreach (directed[i]) pending_blocks.push_back(directed[i]);
    pending_blocks.push_back('{hi: 64'h80000000_00000000, lo: 64'h1});
    pending_blocks.push_back('{hi: 64'h1, lo: 64'h80000000_00000000});
    drain();
    write_key(ADDR_KEY_HIGH, '0);
    write_key(ADDR_KEY_LOW, '0);
    foreach (directed[i]) pending_blocks.push_back(directed[i]);
    drain();
    write_key(ADDR_KEY_HIGH, '1);
    write_key(ADDR_KEY_LOW, '1);
    foreach (directed[i]) pending_blocks.push_back(directed[i]);
    drain();

    // Random phases under each idling mix, new random key per phase.
    for (int ph = 0; ph < 8; ph++) begin
      write_key(ADDR_KEY_HIGH, {$urandom, $urandom});
      write_key(ADDR_KEY_LOW, {$urandom, $urandom});
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // Long receiver hold while the sender keeps offering blocks.
      if (ph == 0) hold_req = hold_req + 1;
      queue_random(160);
      drain();
    end
    idle_pct = 0; stall_pct = 0;

    $display("Covered %0d blocks in, %0d ciphertexts out, over 12 key settings",
             accepted_in, accepted_out);
    $display("with zero-store, fixed, extreme and random keys under stall mixes.");
    if (errors == 0 && expected_cipher.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
